[design/utc_calendar_to_unix_seconds_assert.svh]
// assertion macros for the utc calendar to unix seconds block
// no dependencies; included by utc_calendar_to_unix_seconds.sv, which checks its own pipeline
`ifndef UTC_CALENDAR_TO_UNIX_SECONDS_ASSERT_SVH
`define UTC_CALENDAR_TO_UNIX_SECONDS_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define UTCCAL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("utc calendar pipeline check failed");

// next-cycle implication, disabled while reset is asserted
`define UTCCAL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("utc calendar pipeline check failed");

`endif

[design/utccal_pkg.sv]
// types, constants and the month table for the utc calendar to unix seconds block
// no dependencies; used by utccal_day_count and the top level
`timescale 1ns / 1ps

package utccal_pkg;

    // year offset from 1900 after month roll-over (0..532)
    typedef logic [9:0] year_off_t;
    // month within year (0..11)
    typedef logic [3:0] month_t;
    // signed day count from the epoch
    typedef logic signed [19:0] days_t;
    // signed seconds within a day, daylight hour already removed
    typedef logic signed [17:0] tod_t;
    // result seconds
    typedef logic signed [35:0] unix_secs_t;

    // floor(mon / 12) as (mon * 171) >> 11, exact for 8-bit mon
    localparam logic [7:0] MONTH_RECIP_MUL   = 8'd171;
    localparam int         MONTH_RECIP_SHIFT = 11;
    localparam logic [7:0] MONTHS_PER_YEAR   = 8'd12;

    localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
    // 1900-01-01 to epoch (70 * 365 + 17 leap days) plus one for day numbering from 1
    localparam logic [19:0] DAY_BIAS        = 20'd25568;
    localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
    localparam logic [5:0]  SECS_PER_MINUTE = 6'd60;
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;

    // daylight flag code that removes one hour
    localparam logic signed [1:0] DST_ACTIVE = 2'sb01;

    // cumulative days before each month of a common year
    function automatic logic [8:0] days_before_month(input month_t m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[design/utccal_day_count.sv]
// day count from 1970-01-01 for a normalized year offset, month and day
// depends on utccal_pkg
`timescale 1ns / 1ps

module utccal_day_count (
    input  utccal_pkg::year_off_t year_off,   // calendar year minus 1900
    input  utccal_pkg::month_t    month,      // 0..11
    input  logic [4:0]            mday,       // day of month from one
    output utccal_pkg::days_t     days
);

    logic [18:0] year_days;
    logic [2:0]  centuries;
    logic [1:0]  quad_centuries;
    logic        is_century;
    logic        is_leap;
    logic        leap_early;
    logic [19:0] sum;

    // whole centuries and 400-year periods, offsets relative to 1900 and 1600
    always_comb begin
        year_days = 19'(year_off) * 19'(utccal_pkg::DAYS_PER_YEAR);

        if (year_off >= 10'd500) begin
            centuries = 3'd5;
        end else if (year_off >= 10'd400) begin
            centuries = 3'd4;
        end else if (year_off >= 10'd300) begin
            centuries = 3'd3;
        end else if (year_off >= 10'd200) begin
            centuries = 3'd2;
        end else if (year_off >= 10'd100) begin
            centuries = 3'd1;
        end else begin
            centuries = 3'd0;
        end

        if (year_off >= 10'd500) begin
            quad_centuries = 2'd2;
        end else if (year_off >= 10'd100) begin
            quad_centuries = 2'd1;
        end else begin
            quad_centuries = 2'd0;
        end
    end

    // gregorian leap rule; 2000 and 2400 are the only centuries that leap here
    always_comb begin
        is_century = year_off inside {10'd0, 10'd100, 10'd200, 10'd300, 10'd400, 10'd500};
        is_leap    = (year_off[1:0] == 2'd0) &&
                     (!is_century || (year_off == 10'd100) || (year_off == 10'd500));
        leap_early = is_leap && (month < 4'd2);
    end

    // sum of all day terms, wraps correctly into the signed result
    always_comb begin
        sum = 20'(year_days)
            + 20'(utccal_pkg::days_before_month(month))
            + 20'(year_off[9:2])
            + 20'(quad_centuries)
            + 20'(mday)
            - 20'(centuries)
            - 20'(leap_early)
            - utccal_pkg::DAY_BIAS;
        days = $signed(sum);
    end

endmodule

[design/utc_calendar_to_unix_seconds.sv]
// broken-down utc date and time to signed seconds since 1970-01-01
// depends on utccal_pkg, utccal_day_count and utc_calendar_to_unix_seconds_assert.svh
// throughput: one beat per cycle unless the output stalls; stage depth is set by the
//   month divide, day count sum, 86400 multiply and final sum, each in a stage of its own
// reset: synchronous active-low aresetn clears the stage valid bits only
`timescale 1ns / 1ps

`include "utc_calendar_to_unix_seconds_assert.svh"

module utc_calendar_to_unix_seconds (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // years_since_1900[8:0], month_index[16:9], day_of_month[21:17],
    // hour_of_day[26:22], minute_of_hour[32:27], second_of_minute[38:33], zero[39]
    input  logic [39:0] s_tdata,
    // daylight_flag[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // unix_seconds[35:0], zero[39:36]
    output logic [39:0] m_tdata
);

    localparam utccal_pkg::days_t DAYS_MIN = -20'sd25568;
    localparam utccal_pkg::days_t DAYS_MAX = 20'sd169107;

    // input field split
    logic [8:0]        in_years;
    logic [7:0]        in_month;
    logic [4:0]        in_mday;
    logic [4:0]        in_hour;
    logic [5:0]        in_minute;
    logic [5:0]        in_second;
    logic signed [1:0] in_dst;

    assign in_years  = s_tdata[8:0];
    assign in_month  = s_tdata[16:9];
    assign in_mday   = s_tdata[21:17];
    assign in_hour   = s_tdata[26:22];
    assign in_minute = s_tdata[32:27];
    assign in_second = s_tdata[38:33];
    assign in_dst    = $signed(s_tuser);

    // stage valid bits and advance enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !s4_valid_reg || m_tready;
    assign adv3     = !s3_valid_reg || adv4;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                s1_valid_reg <= s_tvalid;
            end
            if (adv2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage 1: month roll-over into the year
    logic [15:0]                month_prod;
    logic [4:0]                 year_carry;
    utccal_pkg::year_off_t      s1_year_next, s1_year_reg;
    utccal_pkg::month_t         s1_month_next, s1_month_reg;
    logic [4:0]                 s1_mday_reg, s1_hour_reg;
    logic [5:0]                 s1_minute_reg, s1_second_reg;
    logic signed [1:0]          s1_dst_reg;

    always_comb begin
        month_prod    = 16'(in_month) * 16'(utccal_pkg::MONTH_RECIP_MUL);
        year_carry    = month_prod[utccal_pkg::MONTH_RECIP_SHIFT +: 5];
        s1_year_next  = 10'(in_years) + 10'(year_carry);
        s1_month_next = 4'(in_month - 8'(8'(year_carry) * utccal_pkg::MONTHS_PER_YEAR));
    end

    always_ff @(posedge aclk) begin
        if (adv1 && s_tvalid) begin
            s1_year_reg   <= s1_year_next;
            s1_month_reg  <= s1_month_next;
            s1_mday_reg   <= in_mday;
            s1_hour_reg   <= in_hour;
            s1_minute_reg <= in_minute;
            s1_second_reg <= in_second;
            s1_dst_reg    <= in_dst;
        end
    end

    // stage 2: day count and seconds within the day
    utccal_pkg::days_t s2_days_next, s2_days_reg;
    logic [16:0]       tod_base;
    utccal_pkg::tod_t  s2_tod_next, s2_tod_reg;

    utccal_day_count u_day_count (
        .year_off (s1_year_reg),
        .month    (s1_month_reg),
        .mday     (s1_mday_reg),
        .days     (s2_days_next)
    );

    always_comb begin
        tod_base = 17'(s1_hour_reg) * 17'(utccal_pkg::SECS_PER_HOUR)
                 + 17'(s1_minute_reg) * 17'(utccal_pkg::SECS_PER_MINUTE)
                 + 17'(s1_second_reg);
        s2_tod_next = $signed({1'b0, tod_base});
        if (s1_dst_reg == utccal_pkg::DST_ACTIVE) begin
            s2_tod_next = s2_tod_next - $signed({6'b0, utccal_pkg::SECS_PER_HOUR});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && s1_valid_reg) begin
            s2_days_reg <= s2_days_next;
            s2_tod_reg  <= s2_tod_next;
        end
    end

    // stage 3: days to seconds
    logic signed [37:0]     day_secs_full;
    utccal_pkg::unix_secs_t s3_day_secs_reg;
    utccal_pkg::tod_t       s3_tod_reg;

    assign day_secs_full = s2_days_reg * $signed({1'b0, utccal_pkg::SECS_PER_DAY});

    always_ff @(posedge aclk) begin
        if (adv3 && s2_valid_reg) begin
            s3_day_secs_reg <= day_secs_full[35:0];
            s3_tod_reg      <= s2_tod_reg;
        end
    end

    // stage 4: final sum into the output register
    utccal_pkg::unix_secs_t s4_total_next, s4_total_reg;

    assign s4_total_next = s3_day_secs_reg + 36'(s3_tod_reg);

    always_ff @(posedge aclk) begin
        if (adv4 && s3_valid_reg) begin
            s4_total_reg <= s4_total_next;
        end
    end

    assign m_tvalid = s4_valid_reg;
    assign m_tdata  = {4'b0, s4_total_reg};

    // pipeline checks
    `UTCCAL_ASSERT_IMP(a_full_when_blocked, aclk, aresetn, !s_tready, s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg)
    `UTCCAL_ASSERT_IMP(a_ready_when_drained, aclk, aresetn, m_tready, s_tready)
    `UTCCAL_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, s1_valid_reg)
    `UTCCAL_ASSERT_IMP(a_days_range, aclk, aresetn, s2_valid_reg, (s2_days_reg >= DAYS_MIN) && (s2_days_reg <= DAYS_MAX))

endmodule

[tb/utc_calendar_to_unix_seconds_tb.sv]
// self-checking testbench for utc_calendar_to_unix_seconds: directed calendar corners,
// then random dates through random sender gaps and receiver stalls
// depends on utccal_pkg and the utc_calendar_to_unix_seconds rtl
`timescale 1ns / 1ps

module utc_calendar_to_unix_seconds_tb;

    localparam int N_RANDOM      = 1930;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 12;
    localparam int MONTHS_IN_YR  = 12;

    // daylight flag codes besides the package's active code
    localparam logic signed [1:0] DST_NONE     = 2'sb00;
    localparam logic signed [1:0] DST_UNKNOWN  = 2'sb11;
    localparam logic signed [1:0] DST_RESERVED = 2'sb10;

    // days before each month in a common year
    localparam int CUM_DAYS [MONTHS_IN_YR] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct {
        logic [8:0]        years;
        logic [7:0]        month;
        logic [4:0]        mday;
        logic [4:0]        hour;
        logic [5:0]        mins;
        logic [5:0]        secs;
        logic signed [1:0] dst;
    } cal_fields_t;

    // expected unix seconds, one per accepted input beat
    class unix_time_scoreboard;
        utccal_pkg::unix_secs_t pending_secs[$];
        int n_noted;
        int n_checked;
        int n_errors;
        int n_dst_hour;

        function automatic longint floor_quot(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        // gregorian day count, linear time-of-day sum, optional daylight hour
        function automatic utccal_pkg::unix_secs_t predict_seconds(cal_fields_t f);
            longint yr;
            longint mo;
            longint days;
            longint total;
            bit     leap;
            yr   = 1900 + longint'(f.years) + longint'(f.month) / MONTHS_IN_YR;
            mo   = longint'(f.month) % MONTHS_IN_YR;
            days = (yr - 1970) * 365 + CUM_DAYS[mo];
            days = days + floor_quot(yr - 1968, 4);
            days = days - floor_quot(yr - 1900, 100);
            days = days + floor_quot(yr - 1600, 400);
            leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            // leap day of this year not reached yet in january and february
            if (leap && mo < 2)
                days = days - 1;
            days  = days + longint'(f.mday) - 1;
            total = ((days * 24 + longint'(f.hour)) * 60 + longint'(f.mins)) * 60
                    + longint'(f.secs);
            if (f.dst == utccal_pkg::DST_ACTIVE)
                total = total - 3600;
            return total[35:0];
        endfunction

        function void note_input(cal_fields_t f);
            pending_secs.push_back(predict_seconds(f));
            n_noted++;
            if (f.dst == utccal_pkg::DST_ACTIVE)
                n_dst_hour++;
        endfunction

        function void check_result(logic [39:0] beat);
            utccal_pkg::unix_secs_t got;
            utccal_pkg::unix_secs_t want;
            got = beat[35:0];
            if (pending_secs.size() == 0) begin
                $display("%0t ERROR result beat with nothing pending: expected none, got %0d",
                         $time, got);
                n_errors++;
                return;
            end
            want = pending_secs.pop_front();
            n_checked++;
            if (got !== want) begin
                $display("%0t ERROR unix_seconds mismatch: expected %0d, got %0d",
                         $time, want, got);
                n_errors++;
            end
        endfunction

        function int pending();
            return pending_secs.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    unix_time_scoreboard sb = new();

    int idle_cycles = 0;
    int rx_stall_left = 0;
    bit rx_steady = 1'b0;
    bit tx_steady = 1'b0;

    utc_calendar_to_unix_seconds u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic cal_fields_t make_fields(int yrs, int mon, int md, int hr, int mi,
                                                int sc, logic signed [1:0] ds);
        cal_fields_t f;
        f.years = yrs[8:0];
        f.month = mon[7:0];
        f.mday  = md[4:0];
        f.hour  = hr[4:0];
        f.mins  = mi[5:0];
        f.secs  = sc[5:0];
        f.dst   = ds;
        return f;
    endfunction

    // mostly calendar-valid fields, the rest anywhere in the field width
    function automatic cal_fields_t random_fields();
        cal_fields_t f;
        f.years = 9'($urandom_range(0, 511));
        f.month = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 11)
                                                : $urandom_range(0, 255));
        f.mday  = 5'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 31)
                                                : $urandom_range(0, 31));
        f.hour  = 5'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 23)
                                                : $urandom_range(0, 31));
        f.mins  = 6'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 59)
                                                : $urandom_range(0, 63));
        f.secs  = 6'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 60)
                                                : $urandom_range(0, 63));
        f.dst   = 2'($urandom_range(0, 3));
        return f;
    endfunction

    // present one beat and hold it until the block takes it
    task automatic send_beat(cal_fields_t f);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, f.secs, f.mins, f.hour, f.mday, f.month, f.years};
        s_tuser  <= f.dst;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(f);
    endtask

    task automatic idle_sender(int n);
        s_tvalid <= 1'b0;
        s_tdata  <= 40'({$urandom, $urandom});
        repeat (n) @(posedge aclk);
    endtask

    // hold off the sender until every pending result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic send_with_gap(cal_fields_t f);
        int gap;
        send_beat(f);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
            idle_sender(gap);
    endtask

    // receiver: random stalls, with stretches of steady ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready      <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
            rx_stall_left <= pick_gap();
            m_tready      <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 299) == 0)
            rx_steady <= ~rx_steady;
    end

    // result beat monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // watchdog on cycles without any beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int n_directed;
        n_directed = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // epoch and the field extremes
        send_with_gap(make_fields(70, 0, 1, 0, 0, 0, DST_NONE));
        send_with_gap(make_fields(0, 0, 0, 0, 0, 0, DST_NONE));
        send_with_gap(make_fields(511, 255, 31, 31, 63, 63, DST_UNKNOWN));
        // leap day of 1968 and the last second of 1967, before the floor matters
        send_with_gap(make_fields(68, 1, 29, 12, 0, 0, DST_NONE));
        send_with_gap(make_fields(67, 11, 31, 23, 59, 59, DST_NONE));
        send_with_gap(make_fields(1, 0, 1, 0, 0, 0, DST_NONE));
        // century rules: 1900 and 2100 common, 2000 and 2400 leap
        send_with_gap(make_fields(0, 1, 28, 0, 0, 0, DST_NONE));
        send_with_gap(make_fields(100, 1, 29, 0, 0, 0, DST_NONE));
        send_with_gap(make_fields(100, 2, 1, 0, 0, 0, DST_NONE));
        send_with_gap(make_fields(200, 1, 28, 0, 0, 0, DST_NONE));
        send_with_gap(make_fields(200, 2, 1, 0, 0, 0, DST_NONE));
        send_with_gap(make_fields(500, 1, 29, 0, 0, 0, DST_NONE));
        // month roll-over into later years, also landing on a leap february
        send_with_gap(make_fields(70, 12, 1, 0, 0, 0, DST_NONE));
        send_with_gap(make_fields(99, 13, 1, 0, 0, 0, DST_NONE));
        send_with_gap(make_fields(99, 255, 15, 6, 30, 30, DST_NONE));
        // leap second
        send_with_gap(make_fields(70, 0, 1, 0, 0, 60, DST_NONE));
        // every daylight flag value
        send_with_gap(make_fields(70, 0, 1, 1, 0, 0, utccal_pkg::DST_ACTIVE));
        send_with_gap(make_fields(70, 0, 1, 1, 0, 0, DST_RESERVED));
        send_with_gap(make_fields(70, 0, 1, 1, 0, 0, DST_UNKNOWN));
        send_with_gap(make_fields(0, 0, 1, 0, 0, 0, utccal_pkg::DST_ACTIVE));
        // day zero with over-range time fields, then 2038-01-19 03:14:07
        send_with_gap(make_fields(120, 5, 0, 31, 63, 63, DST_NONE));
        send_with_gap(make_fields(138, 0, 19, 3, 14, 7, DST_NONE));
        n_directed = sb.n_noted;

        drain_results();

        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 199) == 0)
                tx_steady = ~tx_steady;
            if (i == N_RANDOM / 2)
                drain_results();
            send_with_gap(random_fields());
        end
        idle_sender(1);

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d beats (%0d directed, %0d random), %0d with the daylight hour",
                 sb.n_noted, n_directed, sb.n_noted - n_directed, sb.n_dst_hour);
        $display("years 1900 to 2432 with month roll-over; %0d results checked, %0d left over",
                 sb.n_checked, sb.pending());
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
